>>> src/sorted_run_fence_lookup_assert.svh
// Assertion macros used by the sorted run lookup top level.
`ifndef SORTED_RUN_FENCE_LOOKUP_ASSERT_SVH
`define SORTED_RUN_FENCE_LOOKUP_ASSERT_SVH

// Checked only while out of reset.
`define SRFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SRFL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/srfl_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package srfl_pkg;

  localparam int RUN_DEPTH    = 1024;
  localparam int PAGE_ENTRIES = 64;
  localparam int KEY_WIDTH    = 32;
  localparam int VALUE_WIDTH  = 32;

  localparam int FENCE_DEPTH = (RUN_DEPTH + PAGE_ENTRIES - 1) / PAGE_ENTRIES;
  localparam int IDX_W       = $clog2(RUN_DEPTH);
  localparam int CNT_W       = $clog2(RUN_DEPTH + 1);
  localparam int FIDX_W      = (FENCE_DEPTH > 1) ? $clog2(FENCE_DEPTH) : 1;
  localparam int FCNT_W      = $clog2(FENCE_DEPTH + 1);
  localparam int PPOS_W      = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;
  localparam int IN_DATA_W   = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam int CAP_W      = 11;
  localparam int CAP_RESET  = 1024;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Operation codes carried in the input tuser.
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // Word index of the capacity register on the configuration port.
  localparam logic [APB_ADDR_W-3:0] REG_RUN_CAPACITY = '0;

  typedef enum logic [1:0] {
    RES_PUT_OK,
    RES_PUT_REJ,
    RES_MISS,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    logic      take_item;
    logic      do_put;
    logic      search_init;
    logic      search_step;
    logic      scan_init;
    logic      scan_step;
    logic      set_res;
    res_kind_t res_kind;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_get;
    logic can_put;
    logic in_range;
    logic search_done;
    logic scan_hit;
    logic scan_end;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> src/srfl_ctrl.sv
// Controller state machine that sequences puts, fence search and page scan.
`default_nettype none

module srfl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  input  wire srfl_pkg::dp_stat_t stat,
  output srfl_pkg::dp_cmd_t      cmd
);
  import srfl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.is_get) begin
          cmd.do_put   = stat.can_put;
          cmd.set_res  = 1'b1;
          cmd.res_kind = stat.can_put ? RES_PUT_OK : RES_PUT_REJ;
          state_nxt    = S_DONE;
        end else if (!stat.in_range) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_MISS;
          state_nxt    = S_DONE;
        end else begin
          cmd.search_init = 1'b1;
          state_nxt       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_HIT;
          state_nxt    = S_DONE;
        end else if (stat.scan_end) begin
          cmd.set_res  = 1'b1;
          cmd.res_kind = RES_MISS;
          state_nxt    = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_DONE: begin
        // The finished result moves to the output register once it is free.
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> src/srfl_dp.sv
// Datapath: entry memory, fence registers, search and scan counters, result registers.
`default_nettype none

module srfl_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [srfl_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire logic                                 in_tuser,
  input  wire logic [srfl_pkg::CAP_W-1:0]           run_capacity,
  input  wire srfl_pkg::dp_cmd_t                    cmd,
  output srfl_pkg::dp_stat_t                        stat,
  output logic [srfl_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic [1:0]                                out_tuser
);
  import srfl_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CNT_W:0] PG_LEN = (CNT_W + 1)'(PAGE_ENTRIES);

  // Item registers.
  logic                   op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // Run state.
  logic [CNT_W-1:0]       count_r;
  logic [FCNT_W-1:0]      fence_cnt_r;
  logic [PPOS_W-1:0]      page_pos_r;
  logic [KEY_WIDTH-1:0]   largest_r;
  logic [KEY_WIDTH-1:0]   fence_mem [FENCE_DEPTH];
  logic [ENTRY_W-1:0]     entry_mem [RUN_DEPTH];

  // Search and scan.
  logic [FCNT_W-1:0]      lo_r, hi_r;
  logic [CNT_W-1:0]       issue_r, stop_r;
  logic                   pend_r;
  logic [ENTRY_W-1:0]     rd_data_r;

  // Result and output registers.
  logic                   res_hit_r, res_rej_r;
  logic [VALUE_WIDTH-1:0] res_val_r;
  logic                   out_hit_r, out_rej_r;
  logic [VALUE_WIDTH-1:0] out_val_r;

  logic [FCNT_W-1:0]      mid;
  logic [KEY_WIDTH-1:0]   mid_fence;
  logic [FCNT_W-1:0]      page;
  logic [CNT_W:0]         start_ext, stop_ext;
  logic [CNT_W-1:0]       stop_val;
  logic                   mem_we, mem_re;
  logic [KEY_WIDTH-1:0]   rd_key;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_fence = fence_mem[mid[FIDX_W-1:0]];
  assign page      = (lo_r == '0) ? '0 : lo_r - 1'b1;
  assign start_ext = (CNT_W + 1)'(page) * PG_LEN;
  assign stop_ext  = start_ext + PG_LEN;
  assign stop_val  = (stop_ext > {1'b0, count_r}) ? count_r : stop_ext[CNT_W-1:0];
  assign mem_we    = cmd.do_put;
  assign mem_re    = cmd.scan_step && (issue_r < stop_r);
  assign rd_key    = rd_data_r[ENTRY_W-1:VALUE_WIDTH];

  always_comb begin
    stat.is_get      = (op_r == CMD_GET);
    stat.can_put     = (CMP_W'(count_r) < CMP_W'(run_capacity))
                    && (CMP_W'(count_r) < CMP_W'(RUN_DEPTH));
    stat.in_range    = (count_r != '0) && !(key_r < fence_mem[0]) && !(key_r > largest_r);
    stat.search_done = !(lo_r < hi_r);
    stat.scan_hit    = pend_r && (rd_key == key_r);
    stat.scan_end    = !pend_r && !(issue_r < stop_r);
  end

  // Entry memory: one write port for puts, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[count_r[IDX_W-1:0]] <= {key_r, val_r};
    end
    if (mem_re) begin
      rd_data_r <= entry_mem[issue_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_put && (page_pos_r == '0)) begin
      fence_mem[fence_cnt_r[FIDX_W-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fence_cnt_r <= '0;
      page_pos_r  <= '0;
      largest_r   <= '0;
      pend_r      <= 1'b0;
    end else begin
      if (cmd.do_put) begin
        count_r <= count_r + 1'b1;
        if (page_pos_r == '0) begin
          fence_cnt_r <= fence_cnt_r + 1'b1;
        end
        if (page_pos_r == PPOS_W'(PAGE_ENTRIES - 1)) begin
          page_pos_r <= '0;
        end else begin
          page_pos_r <= page_pos_r + 1'b1;
        end
        if (key_r > largest_r) begin
          largest_r <= key_r;
        end
      end
      if (cmd.scan_init) begin
        pend_r <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r <= mem_re;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KEY_WIDTH-1:0];
      val_r <= in_tdata[ENTRY_W-1:KEY_WIDTH];
    end
    // Upper-bound search: find the first fence above the key.
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= fence_cnt_r;
    end else if (cmd.search_step) begin
      if (mid_fence > key_r) begin
        hi_r <= mid;
      end else begin
        lo_r <= mid + 1'b1;
      end
    end
    // Reads are issued every cycle of the scan up to the page end; their data is compared in the cycle after issue.
    if (cmd.scan_init) begin
      issue_r <= start_ext[CNT_W-1:0];
      stop_r  <= stop_val;
    end else if (mem_re) begin
      issue_r <= issue_r + 1'b1;
    end
    if (cmd.set_res) begin
      case (cmd.res_kind)
        RES_HIT: begin
          res_hit_r <= 1'b1;
          res_rej_r <= 1'b0;
          res_val_r <= rd_data_r[VALUE_WIDTH-1:0];
        end
        RES_PUT_REJ: begin
          res_hit_r <= 1'b0;
          res_rej_r <= 1'b1;
          res_val_r <= '0;
        end
        default: begin
          res_hit_r <= 1'b0;
          res_rej_r <= 1'b0;
          res_val_r <= '0;
        end
      endcase
    end
    if (cmd.load_out) begin
      out_hit_r <= res_hit_r;
      out_rej_r <= res_rej_r;
      out_val_r <= res_val_r;
    end
  end

  assign out_tdata = OUT_DATA_W'(out_val_r);
  assign out_tuser = {out_rej_r, out_hit_r};

endmodule

`default_nettype wire

>>> src/sorted_run_fence_lookup.sv
// Top level of the sorted run lookup: configuration register, controller and datapath.
//
//   channel  | role         | contents
//   ---------+--------------+---------------------------------------------------
//   in_      | stream slave | tdata: key_in[31:0], value_in[63:32]; tuser: cmd
//   out_     | stream master| tdata: value_out[31:0]; tuser: hit[0], rejected[1]
//   cfg_     | APB slave    | word 0 (byte 0): run_capacity[10:0]
//
// A put goes from acceptance through the execute state to the output register.
// A get that misses early does the same; else it runs a binary search over the
// fences (16 at most), sets up the scan, and scans one page of up to 64 entries
// through the entry memory's single registered read port, stopping on a hit.
// Reset clears the control state and counters at once; the stores need no
// clearing pass. A result waits in the output register while the next
// transaction is accepted; a later result waits in the controller until it is free.
`default_nettype none

`include "sorted_run_fence_lookup_assert.svh"

module sorted_run_fence_lookup (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tdata: key_in [31:0], value_in [63:32]
  input  wire logic [srfl_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: cmd [0]
  input  wire logic                                in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata: value_out [31:0]
  output logic [srfl_pkg::OUT_DATA_W-1:0]          out_tdata,
  // tuser: hit [0], rejected [1]
  output logic [1:0]                               out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [srfl_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [srfl_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [srfl_pkg::APB_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);
  import srfl_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             cap_we;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign cfg_pready = 1'b1;
  assign cap_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                   && (cfg_paddr[APB_ADDR_W-1:2] == REG_RUN_CAPACITY);
  assign cfg_prdata = (cfg_paddr[APB_ADDR_W-1:2] == REG_RUN_CAPACITY)
                   ? APB_DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RESET);
    end else if (cap_we) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  srfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  srfl_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .run_capacity (cap_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

  // One transaction is worked on at a time.
  `SRFL_ASSERT(a_one_at_a_time, (in_tvalid && in_tready) |=> !in_tready, "item taken while busy")
  // A result is never both a hit and a refused put.
  `SRFL_ASSERT(a_hit_not_rej, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "hit and reject")
  // Coming out of reset the block is idle with no result pending.
  `SRFL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (in_tready && !out_tvalid), "busy after reset")
  // A datapath command only starts a scan once the search has converged.
  `SRFL_ASSERT(a_scan_after_search, cmd.scan_init |-> stat.search_done, "early scan")

endmodule

`default_nettype wire

>>> bench/sorted_run_fence_lookup_tb.sv
// Self-checking testbench for the sorted run lookup with fence pointers.
`default_nettype none

module sorted_run_fence_lookup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srfl_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = {REG_RUN_CAPACITY, 2'b00};

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        rejected;
  } lookup_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the run as the block should hold it.
  logic [31:0] run_keys [RUN_DEPTH];
  logic [31:0] run_values [RUN_DEPTH];
  logic [31:0] fence_keys [FENCE_DEPTH];
  int unsigned run_count = 0;
  logic [31:0] run_top_key = '0;
  int unsigned run_capacity_reg = CAP_RESET;

  lookup_reply_t predicted_replies[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   replies_seen = 0;
  int unsigned   hits_seen = 0;
  int unsigned   rejects_seen = 0;
  int unsigned   stall_cycles = 0;
  bit            steady_flow = 1'b0;

  sorted_run_fence_lookup u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),    // key_in [31:0], value_in [63:32]
    .in_tuser   (in_tuser),    // cmd [0]
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),   // value_out [31:0]
    .out_tuser  (out_tuser),   // hit [0], rejected [1]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(7, 0);
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  // Applies one transaction to the shadow run and returns the reply it should produce.
  function automatic lookup_reply_t predict_reply(logic cmd, logic [31:0] key,
                                                  logic [31:0] value);
    lookup_reply_t reply;
    int unsigned   limit, lo, hi, mid, page, first, stop, i;
    reply = '0;
    if (cmd == CMD_PUT) begin
      limit = (run_capacity_reg > RUN_DEPTH) ? RUN_DEPTH : run_capacity_reg;
      if (run_count >= limit) begin
        reply.rejected = 1'b1;
        return reply;
      end
      if (run_count % PAGE_ENTRIES == 0)
        fence_keys[run_count / PAGE_ENTRIES] = key;
      if (key > run_top_key)
        run_top_key = key;
      run_keys[run_count] = key;
      run_values[run_count] = value;
      run_count++;
      return reply;
    end
    if (run_count == 0 || key < fence_keys[0] || key > run_top_key)
      return reply;
    // Last fence not above the key picks the page to scan.
    lo = 0;
    hi = (run_count + PAGE_ENTRIES - 1) / PAGE_ENTRIES;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (fence_keys[mid] > key)
        hi = mid;
      else
        lo = mid + 1;
    end
    page = (lo == 0) ? 0 : lo - 1;
    first = page * PAGE_ENTRIES;
    stop = first + PAGE_ENTRIES;
    if (stop > run_count)
      stop = run_count;
    for (i = first; i < stop; i++) begin
      if (run_keys[i] == key) begin
        reply.hit = 1'b1;
        reply.value = run_values[i];
        return reply;
      end
    end
    return reply;
  endfunction

  // Mostly small steps with repeats, now and then a large jump so high key bits get used.
  function automatic logic [31:0] next_put_key();
    logic [63:0] step_key;
    if ($urandom_range(15, 0) == 0)
      step_key = 64'(run_top_key) + $urandom_range(32'h0400_0000, 0);
    else
      step_key = 64'(run_top_key) + $urandom_range(3, 0);
    if (step_key > 64'hFFFF_FF00)
      step_key = 64'(run_top_key);
    return step_key[31:0];
  endfunction

  function automatic logic [31:0] pick_lookup_key();
    int unsigned pick;
    logic [31:0] stored;
    pick = $urandom_range(19, 0);
    if (run_count == 0 || pick < 2)
      return $urandom;
    stored = run_keys[$urandom_range(run_count - 1, 0)];
    if (pick < 12)
      return stored;
    if (pick < 14)
      return stored + 32'd1;
    if (pick < 15)
      return stored - 32'd1;
    if (pick < 17)
      return fence_keys[$urandom_range((run_count - 1) / PAGE_ENTRIES, 0)];
    if (pick == 17)
      return '0;
    if (pick == 18)
      return '1;
    return run_top_key + 32'd1;
  endfunction

  // Leaves tvalid high on return so a back-to-back transaction needs no toggle.
  task automatic send_item(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {value, key};
    in_tuser = cmd;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted_replies.insert(predicted_replies.size(), predict_reply(cmd, key, value));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid = 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] capacity);
    logic [APB_DATA_W-1:0] readback;
    wait_drain();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = CAP_ADDR;
    cfg_pwdata = APB_DATA_W'(capacity);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    run_capacity_reg = capacity;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (readback !== APB_DATA_W'(capacity))
      flag_mismatch("run_capacity readback", APB_DATA_W'(capacity), readback);
  endtask

  task automatic test_empty_run();
    send_item(CMD_GET, '0, $urandom);
    write_capacity('0);
    send_item(CMD_PUT, 32'd7, '1);
    send_item(CMD_GET, '1, '0);
  endtask

  // Four entries with duplicates, then a put past capacity and gets around the edges.
  task automatic test_small_run();
    write_capacity(11'd4);
    send_item(CMD_PUT, 32'd100, '1);
    send_item(CMD_PUT, 32'd100, '0);
    send_item(CMD_PUT, 32'd200, 32'h1234_5678);
    send_item(CMD_PUT, 32'd200, 32'hA5A5_5A5A);
    send_item(CMD_PUT, 32'd250, 32'hDEAD_BEEF);
    send_item(CMD_GET, 32'd100, $urandom);
    send_item(CMD_GET, 32'd200, $urandom);
    send_item(CMD_GET, 32'd150, $urandom);
    send_item(CMD_GET, 32'd99, $urandom);
    send_item(CMD_GET, '0, $urandom);
    send_item(CMD_GET, 32'd250, $urandom);
    send_item(CMD_GET, '1, $urandom);
  endtask

  task automatic test_lowered_capacity();
    write_capacity(11'd1);
    send_item(CMD_GET, 32'd200, $urandom);
    send_item(CMD_PUT, 32'd300, $urandom);
  endtask

  task automatic test_out_of_order_keys();
    write_capacity('1);
    send_item(CMD_PUT, 32'd50, $urandom);
    send_item(CMD_GET, 32'd50, $urandom);
    send_item(CMD_PUT, 32'd300, $urandom);
    send_item(CMD_GET, 32'd300, $urandom);
    send_item(CMD_PUT, 32'd150, $urandom);
    send_item(CMD_GET, 32'd150, $urandom);
  endtask

  task automatic test_random_mix(input logic [CAP_W-1:0] capacity, input int unsigned items,
                                 input int unsigned put_pct, input bit steady);
    logic [31:0] key;
    write_capacity(capacity);
    steady_flow = steady;
    repeat (items) begin
      if ($urandom_range(63, 0) == 0)
        wait_drain();
      if ($urandom_range(99, 0) < put_pct) begin
        // A few puts break the key order on purpose.
        if (run_count != 0 && $urandom_range(15, 0) == 0)
          key = $urandom_range(run_top_key, 0);
        else
          key = next_put_key();
        send_item(CMD_PUT, key, $urandom);
      end else begin
        send_item(CMD_GET, pick_lookup_key(), $urandom);
      end
    end
    steady_flow = 1'b0;
  endtask

  // Fills the run to its full depth, ending on the largest key, then keeps probing it.
  task automatic test_fill_to_depth();
    int unsigned after_full;
    logic [31:0] key;
    write_capacity(11'(CAP_RESET));
    after_full = 0;
    while (after_full < 20) begin
      if (run_count >= RUN_DEPTH)
        after_full++;
      if ($urandom_range(63, 0) == 0)
        wait_drain();
      if (run_count < RUN_DEPTH && $urandom_range(31, 0) != 0) begin
        key = (run_count == RUN_DEPTH - 1) ? '1 : next_put_key();
        send_item(CMD_PUT, key, $urandom);
      end else if (run_count >= RUN_DEPTH && $urandom_range(3, 0) == 0) begin
        send_item(CMD_PUT, next_put_key(), $urandom);
      end else begin
        send_item(CMD_GET, pick_lookup_key(), $urandom);
      end
    end
  endtask

  // Result side: a random stall before each transaction, none in steady stretches.
  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_replies
    lookup_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (out_tuser[0] === 1'b1)
        hits_seen++;
      if (out_tuser[1] === 1'b1)
        rejects_seen++;
      if (predicted_replies.size() == 0) begin
        flag_mismatch("reply with none pending", '0, out_tdata);
      end else begin
        want = predicted_replies.pop_front();
        if (out_tuser[0] !== want.hit)
          flag_mismatch("hit", 32'(want.hit), 32'(out_tuser[0]));
        if (out_tdata !== want.value)
          flag_mismatch("value_out", want.value, out_tdata);
        if (out_tuser[1] !== want.rejected)
          flag_mismatch("rejected", 32'(want.rejected), 32'(out_tuser[1]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d replies still pending", predicted_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_run();
    test_small_run();
    test_lowered_capacity();
    test_out_of_order_keys();
    test_random_mix(11'd300, 200, 80, 1'b0);
    test_random_mix(11'd1, 20, 50, 1'b0);
    test_random_mix('1, 200, 95, 1'b1);
    test_random_mix('1, 200, 95, 1'b0);
    test_fill_to_depth();

    wait_drain();
    repeat (100) @(negedge clk);

    $display("Sent %0d transactions and checked %0d replies: %0d hits, %0d rejected puts.",
             items_sent, replies_seen, hits_seen, rejects_seen);
    $display("Run filled to %0d entries over capacities 0, 1, 4, 300, 1024 and 2047.",
             run_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sorted_run_fence_lookup.f
+incdir+src
src/srfl_pkg.sv
src/srfl_ctrl.sv
src/srfl_dp.sv
src/sorted_run_fence_lookup.sv
bench/sorted_run_fence_lookup_tb.sv
